[rtl/core/swx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swx_pkg;

    // Sine table size
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;

    // Phase increments, Q0.16 turns per unit of y and t
    localparam logic [15:0] PH0_Y = 16'd664;
    localparam logic [15:0] PH0_T = 16'd104;
    localparam logic [15:0] PH1_Y = 16'd415;
    localparam logic [15:0] PH1_T = 16'd2086;

    // Wave amplitudes, Q4.8 (4*pi and 7)
    localparam logic signed [12:0] AMP0_Q8 = 13'sd3217;
    localparam logic signed [12:0] AMP1_Q8 = 13'sd1792;

    // Sine polynomial coefficients
    localparam logic [63:0] POLY_A = 64'd102944;
    localparam logic [63:0] POLY_B = 64'd42047;
    localparam logic [63:0] POLY_C = 64'd4640;

    typedef logic [SINE_TABLE_BITS-1:0] sine_idx_t;
    typedef logic signed [15:0] sine_lut_t [SINE_N];

    // Stage 1 -> 2: phases plus the low coordinate bytes still needed
    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  t;
        logic [15:0] ph0;
        logic [15:0] ph1;
    } phase_item_t;

    // Stage 2 -> 3: Q1.14 sine samples
    typedef struct packed {
        logic [7:0]         x;
        logic [7:0]         y;
        logic [7:0]         t;
        logic signed [15:0] sin0;
        logic signed [15:0] sin1;
    } sine_item_t;

    // Stage 3 -> 4: Q8 wave offsets, modulo 2^16
    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  t;
        logic [15:0] wave0;
        logic [15:0] wave1;
    } wave_item_t;

    // One Q1.14 table entry; evaluated at elaboration only
    function automatic logic signed [15:0] sine_entry(input logic [63:0] idx);
        logic [63:0] quarter;
        logic [63:0] quad;
        logic [63:0] pos;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] inner;
        logic [63:0] t2;
        logic [63:0] s;
        logic [15:0] mag;
        quarter = 64'(SINE_N) >> 2;
        quad    = (idx >> (SINE_TABLE_BITS - 2)) & 64'd3;
        pos     = idx & (quarter - 64'd1);
        if (quad[0])
        begin
            pos = quarter - pos;
        end
        z     = pos << (18 - SINE_TABLE_BITS);
        z2    = (z * z) >> 16;
        inner = POLY_B - ((POLY_C * z2) >> 16);
        t2    = POLY_A - ((z2 * inner) >> 16);
        s     = (z * t2) >> 16;
        if (s > 64'd65536)
        begin
            s = 64'd65536;
        end
        mag = 16'((s + 64'd2) >> 2);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        for (int i = 0; i < SINE_N; i++)
        begin
            lut[i] = sine_entry(64'(i));
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

`default_nettype wire

[rtl/core/sine_warped_xor_texture_pixel.sv]
// A pixel request passes through four register stages (phase, sine table,
// amplitude multiply, coordinate mix), each holding one request; hue is
// taken from the register of the last stage. Throughput: one pixel per clock
// while hue_ready is high.
// A stall on the hue side holds only the stages that are full; bubbles close up.
// Reset (rst_n, async, active low) clears the stage valid bits; no other state.
`timescale 1ns / 1ps
`default_nettype none

module sine_warped_xor_texture_pixel
    import swx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // pixel request channel
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  logic [8:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic [15:0] frame_number,
    // hue result channel
    output logic        hue_valid,
    input  logic        hue_ready,
    output logic [7:0]  hue
);

    // Inter-stage handshakes and payloads
    logic        ph_valid;
    logic        ph_ready;
    phase_item_t ph_item;
    logic        sn_valid;
    logic        sn_ready;
    sine_item_t  sn_item;
    logic        wv_valid;
    logic        wv_ready;
    wave_item_t  wv_item;

    // Stage 1: phase0 = 664*y + 104*t, phase1 = 415*y + 2086*t (Q0.16 turns)
    swx_phase u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pixel_valid),
        .in_ready     (pixel_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .frame_number (frame_number),
        .out_valid    (ph_valid),
        .out_ready    (ph_ready),
        .out_item     (ph_item)
    );

    // Stage 2: two reads of the constant Q1.14 sine table
    swx_sine u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .in_item   (ph_item),
        .out_valid (sn_valid),
        .out_ready (sn_ready),
        .out_item  (sn_item)
    );

    // Stage 3: 4*pi and 7 amplitudes times sine, rounded to Q8
    swx_wave u_wave (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sn_valid),
        .in_ready  (sn_ready),
        .in_item   (sn_item),
        .out_valid (wv_valid),
        .out_ready (wv_ready),
        .out_item  (wv_item)
    );

    // Stage 4: u = x + wave0 - t, v = y + wave1 - 2t, hue = (u ^ v) + 3t
    swx_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wv_valid),
        .in_ready  (wv_ready),
        .in_item   (wv_item),
        .out_valid (hue_valid),
        .out_ready (hue_ready),
        .hue       (hue)
    );

endmodule

`default_nettype wire

[rtl/core/swx_phase.sv]
`timescale 1ns / 1ps
`default_nettype none

// Stage 1: both wave phases in Q0.16 turns
module swx_phase
    import swx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [8:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic [15:0] frame_number,
    output logic        out_valid,
    input  logic        out_ready,
    output phase_item_t out_item
);

    logic        valid_reg;
    logic        valid_next;
    phase_item_t item_reg;
    phase_item_t item_next;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        item_next.x   = pixel_x[7:0];
        item_next.y   = pixel_y;
        item_next.t   = frame_number[7:0];
        item_next.ph0 = PH0_Y * {8'd0, pixel_y} + PH0_T * frame_number;
        item_next.ph1 = PH1_Y * {8'd0, pixel_y} + PH1_T * frame_number;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

[rtl/core/swx_sine.sv]
`timescale 1ns / 1ps
`default_nettype none

// Stage 2: sine table lookups, index is phase truncated to table size
module swx_sine
    import swx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  phase_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output sine_item_t  out_item
);

    logic       valid_reg;
    logic       valid_next;
    sine_item_t item_reg;
    sine_item_t item_next;
    sine_idx_t  idx0;
    sine_idx_t  idx1;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    assign idx0 = in_item.ph0[15 -: SINE_TABLE_BITS];
    assign idx1 = in_item.ph1[15 -: SINE_TABLE_BITS];

    always_comb
    begin
        item_next.x    = in_item.x;
        item_next.y    = in_item.y;
        item_next.t    = in_item.t;
        item_next.sin0 = SINE_LUT[idx0];
        item_next.sin1 = SINE_LUT[idx1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

[rtl/core/swx_wave.sv]
`timescale 1ns / 1ps
`default_nettype none

// Stage 3: amplitude times sine, rounded half up to Q8
module swx_wave
    import swx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sine_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output wave_item_t out_item
);

    logic               valid_reg;
    logic               valid_next;
    wave_item_t         item_reg;
    wave_item_t         item_next;
    logic signed [28:0] prod0;
    logic signed [28:0] prod1;
    logic signed [29:0] rnd0;
    logic signed [29:0] rnd1;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    assign prod0 = 29'(AMP0_Q8) * 29'(in_item.sin0);
    assign prod1 = 29'(AMP1_Q8) * 29'(in_item.sin1);
    assign rnd0  = 30'(prod0) + 30'sd8192;
    assign rnd1  = 30'(prod1) + 30'sd8192;

    always_comb
    begin
        item_next.x     = in_item.x;
        item_next.y     = in_item.y;
        item_next.t     = in_item.t;
        // floor shift by 14, kept modulo 2^16
        item_next.wave0 = rnd0[29:14];
        item_next.wave1 = rnd1[29:14];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

[rtl/core/swx_mix.sv]
`timescale 1ns / 1ps
`default_nettype none

// Stage 4: u, v in Q8.8 modulo 256, XOR of integer parts plus 3t
module swx_mix
    import swx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  wave_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] hue
);

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  hue_reg;
    logic [7:0]  hue_next;
    logic [15:0] u;
    logic [15:0] v;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    assign u = {in_item.x, 8'd0} + in_item.wave0 - {in_item.t, 8'd0};
    assign v = {in_item.y, 8'd0} + in_item.wave1 - {in_item.t[6:0], 9'd0};

    assign hue_next = (u[15:8] ^ v[15:8]) + in_item.t + {in_item.t[6:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hue_reg <= hue_next;
        end
    end

    assign out_valid = valid_reg;
    assign hue       = hue_reg;

endmodule

`default_nettype wire
